### rtl/csi_pkg.sv
// Shared types, constants and the rounding function of the color span interpolator.
// Depends on nothing; every other file of the block imports it.
package csi_pkg;

	// Field widths of the span request and of one sample.
	localparam int CSI_CHANNEL_BITS = 16;
	localparam int CSI_FRAC_BITS    = 16;
	localparam int CSI_COUNT_BITS   = 7;
	localparam int CSI_INDEX_BITS   = 6;
	localparam int CSI_DEFAULT_MAX_SPAN = 64;

	// Divider sizes: the dividend is the channel difference with the fraction bits appended.
	localparam int CSI_SEG_BITS  = CSI_INDEX_BITS;
	localparam int CSI_QUOT_BITS = CSI_CHANNEL_BITS + CSI_FRAC_BITS;

	// Accumulator and step: signed, with headroom above the quotient.
	localparam int CSI_ACC_BITS = CSI_QUOT_BITS + 2;

	localparam logic [CSI_CHANNEL_BITS-1:0] CSI_CH_MAX = '1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} csi_state_t;

	// Round half up, drop the fraction bits and clamp to the channel range.
	function automatic logic [CSI_CHANNEL_BITS-1:0] csi_round_clamp(
		input logic signed [CSI_ACC_BITS-1:0] acc
	);
		logic signed [CSI_ACC_BITS-1:0] rnd;
		logic [CSI_ACC_BITS-CSI_FRAC_BITS-1:0] whole;
		logic [CSI_CHANNEL_BITS-1:0] res;
		rnd = acc + (CSI_ACC_BITS'(1) <<< (CSI_FRAC_BITS - 1));
		whole = rnd[CSI_ACC_BITS-1:CSI_FRAC_BITS];
		if (rnd[CSI_ACC_BITS-1]) begin
			res = '0;
		end else if (whole > (CSI_ACC_BITS-CSI_FRAC_BITS)'(CSI_CH_MAX)) begin
			res = CSI_CH_MAX;
		end else begin
			res = whole[CSI_CHANNEL_BITS-1:0];
		end
		return res;
	endfunction

endpackage

### rtl/color_span_interpolator_top.sv
// Color span interpolator: emits evenly spaced RGB samples between two colors.
// Depends on csi_pkg and csi_step_div.
//
// Usage: a span request (start color, end color, sample_count) is a transfer on
// in_valid/in_ready. The block answers with min(sample_count, MAX_SPAN) sample
// transfers on out_valid/out_ready, indexed from 0, the final one with last_sample
// set. A count of zero produces no samples; a count of one gives the start color.
// The three channel steps are formed by bit-serial dividers, one quotient bit per
// cycle; the first sample is loaded once the divide is done (a single-sample span
// skips the divide). Samples then follow at one per cycle while the receiver
// accepts them on out_ready.
// in_ready is high only while no span is being worked on; the next request is
// taken while the final sample of the previous span still waits in the output
// register. When the receiver stalls, the output register holds its sample and
// the accumulators wait. Reset returns the sequencer to idle with no sample
// pending; no data registers are cleared.
module color_span_interpolator_top
	import csi_pkg::*;
#(
	parameter int MAX_SPAN = CSI_DEFAULT_MAX_SPAN
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [CSI_CHANNEL_BITS-1:0] start_red,
	input  logic [CSI_CHANNEL_BITS-1:0] start_green,
	input  logic [CSI_CHANNEL_BITS-1:0] start_blue,
	input  logic [CSI_CHANNEL_BITS-1:0] end_red,
	input  logic [CSI_CHANNEL_BITS-1:0] end_green,
	input  logic [CSI_CHANNEL_BITS-1:0] end_blue,
	input  logic [CSI_COUNT_BITS-1:0]   sample_count,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [CSI_INDEX_BITS-1:0]   sample_index,
	output logic [CSI_CHANNEL_BITS-1:0] out_red,
	output logic [CSI_CHANNEL_BITS-1:0] out_green,
	output logic [CSI_CHANNEL_BITS-1:0] out_blue,
	output logic                        last_sample
);

	localparam int NumCh = 3;
	localparam int DivCntBits = $clog2(CSI_QUOT_BITS);
	localparam logic [DivCntBits-1:0] DivLast = DivCntBits'(CSI_QUOT_BITS - 1);
	localparam logic [CSI_COUNT_BITS-1:0] MaxSpanC = CSI_COUNT_BITS'(MAX_SPAN);
	localparam logic [CSI_COUNT_BITS-1:0] OneC = CSI_COUNT_BITS'(1);

	csi_state_t state_q, state_d;

	logic [DivCntBits-1:0]     divcnt_q;
	logic [CSI_COUNT_BITS-1:0] n_q;
	logic [CSI_COUNT_BITS-1:0] cnt_q;
	logic [CSI_COUNT_BITS-1:0] n_in;

	logic in_xfer;
	logic div_shift;
	logic emit_load;
	logic emit_last;

	logic [CSI_CHANNEL_BITS-1:0]    start_arr [NumCh];
	logic [CSI_CHANNEL_BITS-1:0]    end_arr   [NumCh];
	logic signed [CSI_ACC_BITS-1:0] step_arr  [NumCh];
	logic signed [CSI_ACC_BITS-1:0] acc_q     [NumCh];
	logic [CSI_CHANNEL_BITS-1:0]    chan_q    [NumCh];

	logic                      out_valid_q;
	logic [CSI_INDEX_BITS-1:0] index_q;
	logic                      last_q;

	assign start_arr[0] = start_red;
	assign start_arr[1] = start_green;
	assign start_arr[2] = start_blue;
	assign end_arr[0]   = end_red;
	assign end_arr[1]   = end_green;
	assign end_arr[2]   = end_blue;

	// Requested count, saturated to the span cap.
	assign n_in    = (sample_count > MaxSpanC) ? MaxSpanC : sample_count;
	assign in_xfer = in_valid && in_ready;

	// One step divider per channel; the divisor is the number of segments.
	for (genvar c = 0; c < NumCh; c++) begin : g_div
		csi_step_div u_div (
			.clk       (clk),
			.load      (in_xfer),
			.shift     (div_shift),
			.start_val (start_arr[c]),
			.end_val   (end_arr[c]),
			.segs      (CSI_SEG_BITS'(n_in - OneC)),
			.single    (n_in == OneC),
			.step      (step_arr[c])
		);
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (n_in == '0) begin
						state_d = ST_IDLE;
					end else if (n_in == OneC) begin
						state_d = ST_EMIT;
					end else begin
						state_d = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (divcnt_q == DivLast) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit_load && emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready  = 1'b0;
		div_shift = 1'b0;
		emit_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_DIV: begin
				div_shift = 1'b1;
			end
			ST_EMIT: begin
				emit_load = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign emit_last = ((cnt_q + OneC) == n_q);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			divcnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_xfer) begin
				divcnt_q <= '0;
			end else if (div_shift) begin
				divcnt_q <= divcnt_q + DivCntBits'(1);
			end
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Span counters and the output sample register.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			n_q   <= n_in;
			cnt_q <= '0;
		end else if (emit_load) begin
			cnt_q <= cnt_q + OneC;
		end
		if (emit_load) begin
			index_q <= cnt_q[CSI_INDEX_BITS-1:0];
			last_q  <= emit_last;
		end
	end

	// Per-channel accumulators: start at the start color, then add the step.
	for (genvar c = 0; c < NumCh; c++) begin : g_acc
		always_ff @(posedge clk) begin
			if (in_xfer) begin
				acc_q[c] <= $signed({2'b00, start_arr[c], {CSI_FRAC_BITS{1'b0}}});
			end else if (emit_load) begin
				acc_q[c]  <= acc_q[c] + step_arr[c];
				chan_q[c] <= csi_round_clamp(acc_q[c]);
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign sample_index = index_q;
	assign out_red      = chan_q[0];
	assign out_green    = chan_q[1];
	assign out_blue     = chan_q[2];
	assign last_sample  = last_q;

	// An empty span leaves the sequencer idle.
	a_zero_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (sample_count == '0) |=> state_q == ST_IDLE)
		else $error("empty span did not return to idle");

	// The sample counter never runs past the span length.
	a_count_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		emit_load |-> cnt_q < n_q)
		else $error("sample counter beyond span length");

	// The divide lasts exactly one pass over the quotient bits.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) && (divcnt_q == DivLast) |=> state_q == ST_EMIT)
		else $error("divide did not hand over to emission");

	// No request is taken while a span is in progress.
	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) || (state_q == ST_EMIT) |-> !in_ready)
		else $error("request accepted during a span");

endmodule

### rtl/csi_step_div.sv
// Bit-serial restoring divider that forms the signed per-channel step of a span.
// Depends on csi_pkg for widths; one quotient bit is produced per shift cycle.
module csi_step_div
	import csi_pkg::*;
(
	input  logic                           clk,
	input  logic                           load,
	input  logic                           shift,
	input  logic [CSI_CHANNEL_BITS-1:0]    start_val,
	input  logic [CSI_CHANNEL_BITS-1:0]    end_val,
	input  logic [CSI_SEG_BITS-1:0]        segs,
	input  logic                           single,
	output logic signed [CSI_ACC_BITS-1:0] step
);

	logic [CSI_QUOT_BITS-1:0] dq_q;
	logic [CSI_SEG_BITS-1:0]  rem_q;
	logic [CSI_SEG_BITS-1:0]  div_q;
	logic                     neg_q;
	logic                     zero_q;

	logic [CSI_CHANNEL_BITS-1:0] mag;
	logic [CSI_SEG_BITS:0]       trial;
	logic                        fits;

	// Magnitude of the channel difference and the sign of the step.
	assign mag = (end_val >= start_val) ? (end_val - start_val) : (start_val - end_val);

	// One restoring step: bring down the next dividend bit and try the divisor.
	assign trial = {rem_q, dq_q[CSI_QUOT_BITS-1]};
	assign fits  = (trial >= {1'b0, div_q});

	always_ff @(posedge clk) begin
		if (load) begin
			dq_q   <= {mag, {CSI_FRAC_BITS{1'b0}}};
			rem_q  <= '0;
			div_q  <= segs;
			neg_q  <= (end_val < start_val);
			zero_q <= single;
		end else if (shift) begin
			dq_q <= {dq_q[CSI_QUOT_BITS-2:0], fits};
			if (fits) begin
				rem_q <= CSI_SEG_BITS'(trial - {1'b0, div_q});
			end else begin
				rem_q <= trial[CSI_SEG_BITS-1:0];
			end
		end
	end

	// A single-sample span has no step at all.
	always_comb begin
		if (zero_q) begin
			step = '0;
		end else if (neg_q) begin
			step = -$signed({2'b00, dq_q});
		end else begin
			step = $signed({2'b00, dq_q});
		end
	end

endmodule
